@@ rtl/pcs_pkg.sv @@
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants of the packet capture statistics block
// Request and counter codes, frame header offsets and the command record
// that travels from the parser to the counter engine.
// ----------------------------------------------------------------------------
package pcs_pkg;

   // Frame geometry
   localparam int HEADER_BYTES    = 14;
   localparam int MAX_FRAME_BYTES = 16384;
   localparam int COUNTER_WIDTH   = 48;
   localparam int NUM_COUNTERS    = 9;
   localparam int POS_W           = 16;

   localparam logic [POS_W-1:0] POS_ETYPE_HI  = 16'd12;
   localparam logic [POS_W-1:0] POS_ETYPE_LO  = 16'd13;
   localparam logic [POS_W-1:0] POS_PROTO     = 16'd23;
   localparam logic [POS_W-1:0] POS_HEADER    = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] POS_MAX       = POS_W'(MAX_FRAME_BYTES);

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_ICMP     = 8'd1;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   // Request kinds on the input channel
   localparam logic [1:0] REQ_BYTE     = 2'd0;
   localparam logic [1:0] REQ_INTERVAL = 2'd1;
   localparam logic [1:0] REQ_TOTAL    = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_SIZE_EN   = 2'd0;
   localparam logic [1:0] CSR_EXP_SIZE  = 2'd1;
   localparam logic [1:0] CSR_PAY_EN    = 2'd2;
   localparam logic [1:0] CSR_FILL      = 2'd3;
   localparam int         CSR_DATA_W    = 16;

   // Counter ids
   localparam logic [3:0] CNT_PKTS     = 4'd0;
   localparam logic [3:0] CNT_BYTES    = 4'd1;
   localparam logic [3:0] CNT_UDP      = 4'd2;
   localparam logic [3:0] CNT_TCP      = 4'd3;
   localparam logic [3:0] CNT_ICMP     = 4'd4;
   localparam logic [3:0] CNT_OTHER_IP = 4'd5;
   localparam logic [3:0] CNT_NON_IP   = 4'd6;
   localparam logic [3:0] CNT_SIZE_MM  = 4'd7;
   localparam logic [3:0] CNT_PAY_MM   = 4'd8;

   // Command kinds in the queue
   localparam logic [1:0] CMD_FRAME    = 2'd0;
   localparam logic [1:0] CMD_RPT_INT  = 2'd1;
   localparam logic [1:0] CMD_RPT_TOT  = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef logic [COUNTER_WIDTH-1:0] counter_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [POS_W-1:0] payload_len;
      logic [3:0]       class_id;
      logic             size_mm;
      logic             pay_mm;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

@@ rtl/pcs_front.sv @@
// ----------------------------------------------------------------------------
// pcs_front: frame parser
// Tracks the byte position inside the current frame, captures ethertype and
// IPv4 protocol, checks payload bytes and issues one command per frame end
// or report request. Holds the configuration registers.
// ----------------------------------------------------------------------------
module pcs_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,
   input  logic [1:0]                   req_tuser,
   input  logic                         req_tlast,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_addr,
   input  logic [pcs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                         queue_full,
   output logic                         cmd_push,
   output pcs_pkg::cmd_type             cmd
);
   import pcs_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      etype_ff, etype_in;
   logic [7:0]       proto_ff, proto_in;
   logic             mm_ff, mm_in;
   logic             size_en_ff;
   logic [15:0]      exp_size_ff;
   logic             pay_en_ff;
   logic [7:0]       fill_ff;

   logic             acc;
   logic             byte_acc;
   logic             in_range;
   logic             is_long;
   logic [POS_W-1:0] payload;

   assign req_tready = !queue_full;
   assign acc        = req_tvalid && req_tready;
   assign byte_acc   = acc && (req_tuser == REQ_BYTE);
   assign in_range   = pos_ff < POS_MAX;

   // Advance the per-frame parse state
   always_comb begin
      pos_in   = pos_ff;
      etype_in = etype_ff;
      proto_in = proto_ff;
      mm_in    = mm_ff;
      if (in_range) begin
         pos_in = pos_ff + 1'b1;
         if (pos_ff == POS_ETYPE_HI) begin
            etype_in[15:8] = req_tdata;
         end
         if (pos_ff == POS_ETYPE_LO) begin
            etype_in[7:0] = req_tdata;
         end
         if (pos_ff == POS_PROTO) begin
            proto_in = req_tdata;
         end
         if (pos_ff >= POS_HEADER && req_tdata != fill_ff) begin
            mm_in = 1'b1;
         end
      end
   end

   // Summarize the frame from its final state
   assign is_long = pos_in >= POS_HEADER;
   assign payload = is_long ? (pos_in - POS_HEADER) : '0;

   always_comb begin
      cmd             = '0;
      cmd.payload_len = payload;
      cmd.size_mm     = size_en_ff && (payload != exp_size_ff);
      cmd.pay_mm      = pay_en_ff && mm_in;
      if (is_long && etype_in == ETHERTYPE_IPV4) begin
         if (pos_in > POS_PROTO && proto_in == PROTO_UDP) begin
            cmd.class_id = CNT_UDP;
         end else if (pos_in > POS_PROTO && proto_in == PROTO_TCP) begin
            cmd.class_id = CNT_TCP;
         end else if (pos_in > POS_PROTO && proto_in == PROTO_ICMP) begin
            cmd.class_id = CNT_ICMP;
         end else begin
            cmd.class_id = CNT_OTHER_IP;
         end
      end else begin
         cmd.class_id = CNT_NON_IP;
      end
      unique case (req_tuser)
         REQ_INTERVAL: cmd.kind = CMD_RPT_INT;
         REQ_TOTAL:    cmd.kind = CMD_RPT_TOT;
         default:      cmd.kind = CMD_FRAME;
      endcase
   end

   assign cmd_push = acc && ((req_tuser == REQ_BYTE && req_tlast) ||
                             req_tuser == REQ_INTERVAL || req_tuser == REQ_TOTAL);

   // Hold parse state; clear it when a frame closes
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         etype_ff <= '0;
         proto_ff <= '0;
         mm_ff    <= 1'b0;
      end else if (byte_acc) begin
         if (req_tlast) begin
            pos_ff   <= '0;
            etype_ff <= '0;
            proto_ff <= '0;
            mm_ff    <= 1'b0;
         end else begin
            pos_ff   <= pos_in;
            etype_ff <= etype_in;
            proto_ff <= proto_in;
            mm_ff    <= mm_in;
         end
      end
   end

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         size_en_ff  <= 1'b0;
         exp_size_ff <= '0;
         pay_en_ff   <= 1'b0;
         fill_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SIZE_EN:  size_en_ff  <= csr_wdata[0];
            CSR_EXP_SIZE: exp_size_ff <= csr_wdata[15:0];
            CSR_PAY_EN:   pay_en_ff   <= csr_wdata[0];
            CSR_FILL:     fill_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

endmodule

@@ rtl/pcs_queue.sv @@
// ----------------------------------------------------------------------------
// pcs_queue: command queue
// Short first-in first-out buffer between the parser and the counter engine.
// ----------------------------------------------------------------------------
module pcs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pcs_pkg::cmd_type        push_cmd,
   output logic                    full,
   input  logic                    pop,
   output pcs_pkg::queue_head_type head
);
   import pcs_pkg::*;

   cmd_type             mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff;

   assign full       = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.cmd   = mem[rd_ptr_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/pcs_back.sv @@
// ----------------------------------------------------------------------------
// pcs_back: counter engine
// Applies frame summaries to the interval and total counter sets and walks
// a set out through the result register on a report request.
// ----------------------------------------------------------------------------
module pcs_back (
   input  logic                            clock,
   input  logic                            reset,
   input  pcs_pkg::queue_head_type         head,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pcs_pkg::COUNTER_WIDTH-1:0] rsp_tdata,
   output logic [3:0]                      rsp_tuser,
   output logic                            rsp_tlast
);
   import pcs_pkg::*;

   counter_type interval_ff [NUM_COUNTERS];
   counter_type total_ff    [NUM_COUNTERS];
   counter_type inc         [NUM_COUNTERS];

   logic        rpt_active_ff;
   logic        rpt_total_ff;
   logic [3:0]  rpt_idx_ff;
   logic        out_free;
   logic        rpt_step;
   logic        rpt_done;
   logic        frame_upd;
   counter_type rpt_value;

   assign out_free  = !rsp_tvalid || rsp_tready;
   assign pop       = head.valid && !rpt_active_ff;
   assign frame_upd = pop && head.cmd.kind == CMD_FRAME;
   assign rpt_step  = rpt_active_ff && out_free;
   assign rpt_done  = rpt_step && rpt_idx_ff == CNT_PAY_MM;
   assign rpt_value = rpt_total_ff ? total_ff[rpt_idx_ff] : interval_ff[rpt_idx_ff];

   // Build the increment of each counter for one frame
   always_comb begin
      for (int k = 0; k < NUM_COUNTERS; k++) begin
         inc[k] = '0;
         if (4'(k) == CNT_PKTS) begin
            inc[k] = counter_type'(1);
         end else if (4'(k) == CNT_BYTES) begin
            inc[k] = counter_type'(head.cmd.payload_len);
         end else if (4'(k) == CNT_SIZE_MM) begin
            inc[k] = counter_type'(head.cmd.size_mm);
         end else if (4'(k) == CNT_PAY_MM) begin
            inc[k] = counter_type'(head.cmd.pay_mm);
         end else begin
            inc[k] = counter_type'(head.cmd.class_id == 4'(k));
         end
      end
   end

   // Update counters; clear the interval set after each report
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            interval_ff[k] <= '0;
            total_ff[k]    <= '0;
         end
      end else if (frame_upd) begin
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            interval_ff[k] <= interval_ff[k] + inc[k];
            total_ff[k]    <= total_ff[k] + inc[k];
         end
      end else if (rpt_done) begin
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            interval_ff[k] <= '0;
         end
      end
   end

   // Report sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         rpt_active_ff <= 1'b0;
         rpt_total_ff  <= 1'b0;
         rpt_idx_ff    <= '0;
      end else if (pop && head.cmd.kind != CMD_FRAME) begin
         rpt_active_ff <= 1'b1;
         rpt_total_ff  <= head.cmd.kind == CMD_RPT_TOT;
         rpt_idx_ff    <= CNT_PKTS;
      end else if (rpt_done) begin
         rpt_active_ff <= 1'b0;
         rpt_idx_ff    <= CNT_PKTS;
      end else if (rpt_step) begin
         rpt_idx_ff <= rpt_idx_ff + 1'b1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (rpt_step) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rpt_step) begin
         rsp_tdata <= rpt_value;
         rsp_tuser <= rpt_idx_ff;
         rsp_tlast <= rpt_idx_ff == CNT_PAY_MM;
      end
   end

endmodule

@@ rtl/packet_capture_statistics.sv @@
// Update: a frame's counters update when the counter engine pops its command from the queue.
// Report: counters leave the result register one per cycle while rsp_tready is high.
// Throughput: 1 byte per cycle; a report holds the counter engine until its last counter
// enters the result register; input stalls once the 4-entry command queue fills behind it.
// Reset (synchronous): counters, parse state and configuration clear at once.
// ----------------------------------------------------------------------------
// packet_capture_statistics: Ethernet frame statistics counter
// Parses frames byte by byte, keeps interval and total counter sets and
// reports nine counters of either set on request.
// ----------------------------------------------------------------------------
module packet_capture_statistics (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // frame_byte
   input  logic [1:0]                        req_tuser,  // req_type
   input  logic                              req_tlast,  // end_of_frame
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pcs_pkg::COUNTER_WIDTH-1:0] rsp_tdata,  // counter_value
   output logic [3:0]                        rsp_tuser,  // counter_id
   output logic                              rsp_tlast,  // last_counter
   input  logic                              csr_we,
   input  logic [1:0]                        csr_addr,
   input  logic [pcs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pcs_pkg::*;

   logic           q_full;
   logic           q_push;
   logic           q_pop;
   cmd_type        q_cmd;
   queue_head_type q_head;

   pcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .queue_full (q_full),
      .cmd_push   (q_push),
      .cmd        (q_cmd)
   );

   pcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head)
   );

   pcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Never write into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("command pushed into full queue");

   // The end mark travels only with the last counter id
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == CNT_PAY_MM)))
      else $error("last_counter out of step with counter_id");

   // A finished counter id is followed by the next one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid |->
         rsp_tuser == $past(rsp_tuser) + 4'd1)
      else $error("report counters out of order");

   // No result right after reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
